### rtl/pcrl_pkg.sv
// Shared types and constants for the PCR PID lock and pacing block.
package pcrl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int PID_W      = 13;
    localparam int PCR_W      = 33;
    localparam int CNT_W      = 3;
    localparam int MS_W       = 27;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX        = 3'd7;
    localparam logic [CNT_W-1:0] FIRST_LOCK_RST = 3'd3;
    localparam logic [CNT_W-1:0] RELOCK_RST     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOCK     = 1'd1;

    // x / 90 is (x >> 1) / 45; the quotient by 45 uses floor(2^37 / 45)
    localparam int             RECIP_SHIFT   = 37;
    localparam logic [31:0]    RECIP_45      = 32'd3054198966;
    localparam logic [PCR_W-1:0] HALF_TICKS_MS = 33'd45;

    typedef struct packed {
        logic             resync;
        logic [PID_W-1:0] pid;
        logic             pcr_present;
        logic [PCR_W-1:0] pcr_value;
    } t_in_item;

    typedef struct packed {
        logic             lock_valid;
        logic [PID_W-1:0] locked_pid;
        logic             pcr_update;
        logic             timing_restarted;
        logic [MS_W-1:0]  elapsed_ms;
    } t_out_item;

    // item between the lock stage and the divider
    typedef struct packed {
        logic             lock_valid;
        logic [PID_W-1:0] locked_pid;
        logic             pcr_update;
        logic             timing_restarted;
        logic [PCR_W-1:0] tick_diff;
    } t_mid_item;

endpackage

### rtl/pcrl_lock.sv
// Candidate table, PID lock and reference base; registers the tick difference per item.
module pcrl_lock #(
    parameter int TABLE_DEPTH = pcrl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcrl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pcrl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pcrl_pkg::t_in_item                  i_in_item,
    input  logic                                i_mid_stall,
    output logic                                o_mid_valid,
    output pcrl_pkg::t_mid_item                 o_mid_item
);
    import pcrl_pkg::*;

    logic [CNT_W-1:0]       r_first_thr;
    logic [CNT_W-1:0]       r_relock_thr;
    logic                   r_lock;
    logic [PID_W-1:0]       r_lock_pid;
    logic [PID_W-1:0]       r_cand_pid [TABLE_DEPTH];
    logic [CNT_W-1:0]       r_cand_cnt [TABLE_DEPTH];
    logic [PCR_W-1:0]       r_ref_base;
    logic                   r_ref_valid;
    logic                   r_mid_valid;
    t_mid_item              r_mid_item;

    logic                   in_acc;
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] empty;
    logic [TABLE_DEPTH-1:0] first_empty;
    logic [CNT_W-1:0]       hit_cnt;
    logic [CNT_W-1:0]       cnt_new;
    logic [CNT_W-1:0]       thr;
    logic [CNT_W-1:0]       thr_eff;
    logic                   is_locked;
    logic                   lock_now;
    logic                   upd;
    logic                   ref_ok;
    logic                   restart;
    logic [PCR_W-1:0]       base;
    t_mid_item              n_mid_item;

    assign o_in_stall = r_mid_valid && i_mid_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        hit_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            empty[i] = (r_cand_cnt[i] == '0);
            hit[i]   = !empty[i] && (r_cand_pid[i] == i_in_item.pid);
            if (hit[i]) begin
                hit_cnt = hit_cnt | ((r_cand_cnt[i] == CNT_MAX) ? CNT_MAX
                                     : r_cand_cnt[i] + CNT_W'(1));
            end
        end
    end

    // isolate the lowest empty entry
    assign first_empty = empty & (~empty + TABLE_DEPTH'(1));

    always_comb begin
        if (|hit) begin
            cnt_new = hit_cnt;
        end else if (|empty) begin
            cnt_new = CNT_W'(1);
        end else begin
            cnt_new = '0;
        end
        thr       = r_lock ? r_relock_thr : r_first_thr;
        thr_eff   = (thr == '0) ? CNT_W'(1) : thr;
        is_locked = r_lock && (i_in_item.pid == r_lock_pid);
        lock_now  = i_in_item.pcr_present && !is_locked && (cnt_new != '0)
                    && (cnt_new >= thr_eff);
        upd       = i_in_item.pcr_present && (is_locked || lock_now);
        ref_ok    = r_ref_valid && !i_in_item.resync && !lock_now;
        restart   = upd && !ref_ok;
        base      = restart ? i_in_item.pcr_value : r_ref_base;

        n_mid_item.lock_valid       = r_lock || lock_now;
        n_mid_item.locked_pid       = lock_now ? i_in_item.pid : r_lock_pid;
        n_mid_item.pcr_update       = upd;
        n_mid_item.timing_restarted = restart;
        n_mid_item.tick_diff        = upd ? (i_in_item.pcr_value - base) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_thr  <= FIRST_LOCK_RST;
            r_relock_thr <= RELOCK_RST;
            r_lock       <= 1'b0;
            r_lock_pid   <= '0;
            r_ref_valid  <= 1'b0;
            r_mid_valid  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_cand_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_LOCK: r_first_thr  <= i_cfg_data;
                    CFG_RELOCK:     r_relock_thr <= i_cfg_data;
                endcase
            end
            if (in_acc) begin
                r_mid_valid <= 1'b1;
            end else if (!i_mid_stall) begin
                r_mid_valid <= 1'b0;
            end
            if (in_acc) begin
                // a new base wins over a seek on the same item
                if (restart) begin
                    r_ref_valid <= 1'b1;
                end else if (i_in_item.resync) begin
                    r_ref_valid <= 1'b0;
                end
                if (lock_now) begin
                    r_lock     <= 1'b1;
                    r_lock_pid <= i_in_item.pid;
                end
                // locked PID carried a PCR: clear table, otherwise count this PID
                if (upd) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        r_cand_cnt[i] <= '0;
                    end
                end else if (i_in_item.pcr_present) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (hit[i]) begin
                            r_cand_cnt[i] <= hit_cnt;
                        end else if (!(|hit) && first_empty[i]) begin
                            r_cand_cnt[i] <= CNT_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid_item <= n_mid_item;
            if (restart) begin
                r_ref_base <= i_in_item.pcr_value;
            end
            if (i_in_item.pcr_present && !upd) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!(|hit) && first_empty[i]) begin
                        r_cand_pid[i] <= i_in_item.pid;
                    end
                end
            end
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid_item  = r_mid_item;

endmodule

### rtl/pcrl_div90.sv
// Two-stage divide of the tick difference by 90 (reciprocal multiply plus one correction).
module pcrl_div90 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_mid_valid,
    output logic                  o_mid_stall,
    input  pcrl_pkg::t_mid_item   i_mid_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pcrl_pkg::t_out_item   o_out_item
);
    import pcrl_pkg::*;

    logic                 r_s2_valid;
    t_mid_item            r_s2_item;
    logic [31:0]          r_s2_half;
    logic [63:0]          r_s2_prod;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 out_free;
    logic                 s2_free;
    logic [31:0]          half;
    logic [MS_W-1:0]      q0;
    logic [PCR_W-1:0]     q0_x45;
    logic [PCR_W-1:0]     rem;
    logic [MS_W-1:0]      quot;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign s2_free     = !r_s2_valid || out_free;
    assign o_mid_stall = !s2_free;
    assign half        = i_mid_item.tick_diff[PCR_W-1:1];

    // q0 is the quotient or one less; the remainder check fixes it
    always_comb begin
        q0     = r_s2_prod[63:RECIP_SHIFT];
        q0_x45 = PCR_W'(q0) * HALF_TICKS_MS;
        rem    = PCR_W'(r_s2_half) - q0_x45;
        quot   = q0 + MS_W'(rem >= HALF_TICKS_MS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_valid <= i_mid_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_mid_valid) begin
            r_s2_item <= i_mid_item;
            r_s2_half <= half;
            r_s2_prod <= 64'(half) * 64'(RECIP_45);
        end
        if (out_free && r_s2_valid) begin
            r_out_item.lock_valid       <= r_s2_item.lock_valid;
            r_out_item.locked_pid       <= r_s2_item.locked_pid;
            r_out_item.pcr_update       <= r_s2_item.pcr_update;
            r_out_item.timing_restarted <= r_s2_item.timing_restarted;
            r_out_item.elapsed_ms       <= quot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/pcr_pid_lock_and_pacing_top.sv
// Top level: PCR PID lock and pacing, lock stage followed by the divide-by-90 pipeline.
// Each item is registered in the lock stage, then in the divider product stage, then in the output stage.
// One item per cycle while not stalled; the lock table and reference update in the accept cycle.
// The divide by 90 is a 32x32 reciprocal multiply, registered, then a one-step correction.
// Reset (i_rst_n low, synchronous): no PID locked, table empty, no reference base,
// thresholds back to 3 and 5, pipeline empty. No clearing pass is needed.
module pcr_pid_lock_and_pacing_top #(
    parameter int TABLE_DEPTH = pcrl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pcrl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pcrl_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pcrl_pkg::t_out_item             o_out_item
);
    import pcrl_pkg::*;

    logic      mid_valid;
    logic      mid_stall;
    t_mid_item mid_item;

    pcrl_lock #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lock (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_mid_stall (mid_stall),
        .o_mid_valid (mid_valid),
        .o_mid_item  (mid_item)
    );

    pcrl_div90 u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_stall (mid_stall),
        .i_mid_item  (mid_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### rtl/pcrl_chk.sv
// Port-level checker for the PCR PID lock and pacing top level, with its bind.
module pcrl_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input pcrl_pkg::t_out_item i_out_item
);
    import pcrl_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.timing_restarted |->
            i_out_item.pcr_update && i_out_item.elapsed_ms == '0)
        else $error("restarted item without update or with nonzero elapsed time");

    a_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.pcr_update |->
            !i_out_item.timing_restarted && i_out_item.elapsed_ms == '0)
        else $error("timing fields set without a PCR update");

    a_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.lock_valid |->
            i_out_item.locked_pid == '0 && !i_out_item.pcr_update)
        else $error("PID or update reported while unlocked");

endmodule

bind pcr_pid_lock_and_pacing_top pcrl_chk u_pcrl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

### test/pcr_pid_lock_and_pacing_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PCR PID lock and pacing block, with its own lock and pacing predictor.
module pcr_pid_lock_and_pacing_top_test;
    import pcrl_pkg::*;

    localparam int CAND_DEPTH      = TABLE_DEPTH_DEF;
    localparam int POOL_N          = 4;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_AT         = 450;
    localparam int HOLD_CYCLES     = 80;
    localparam int QUIET_LIMIT     = 5000;
    localparam logic [PCR_W-1:0] TICKS_PER_MS = 33'd90;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    cfg_sel;
        logic [CFG_DATA_W-1:0]   cfg_val;
        t_in_item                pkt;
        logic                    check;
        t_out_item               want;
    } t_step;

    typedef struct {
        logic [CFG_DATA_W-1:0] first;
        logic [CFG_DATA_W-1:0] relock;
        int unsigned           share;
        int unsigned           pool;
        int unsigned           flood;
    } t_phase;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    t_in_item              in_item = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;

    // sideband for directed rows whose result is typed in
    logic                  row_check = 1'b0;
    t_out_item             row_want = '0;
    logic                  steady = 1'b0;
    int unsigned           items_in = 0;
    int unsigned           faults = 0;

    // predictor state
    logic                  clk_pid_locked = 1'b0;
    logic [PID_W-1:0]      clk_pid = '0;
    logic [PID_W-1:0]      cand_pids [CAND_DEPTH];
    logic [CNT_W-1:0]      cand_hits [CAND_DEPTH];
    logic [PCR_W-1:0]      base_pcr = '0;
    logic                  base_known = 1'b0;
    logic [CNT_W-1:0]      first_thr = FIRST_LOCK_RST;
    logic [CNT_W-1:0]      relock_thr = RELOCK_RST;

    t_out_item             pending_results [$];
    logic [PID_W-1:0]      pid_pool [POOL_N];
    logic [PCR_W-1:0]      stream_pcr = '0;

    t_step script [22] = '{
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b1, 13'h1FFF, 1'b0, 33'h1_FFFF_FFFF}, 1'b1, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'h0}, 1'b1, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'h1_FFFF_FFFF}, 1'b1, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'd100}, 1'b1,
          '{1'b1, 13'h0000, 1'b1, 1'b1, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'd90100}, 1'b1,
          '{1'b1, 13'h0000, 1'b1, 1'b0, 27'd1000}},
        // reference ahead of the PCR: elapsed time wraps
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'd99}, 1'b0, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b1, 13'h0000, 1'b1, 33'd5}, 1'b1,
          '{1'b1, 13'h0000, 1'b1, 1'b1, 27'd0}},
        // seek on a packet without PCR still drops the reference
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b1, 13'h0000, 1'b0, 33'h0_AAAA_AAAA}, 1'b1,
          '{1'b1, 13'h0000, 1'b0, 1'b0, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0000, 1'b1, 33'h1_5555_5555}, 1'b1,
          '{1'b1, 13'h0000, 1'b1, 1'b1, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1FFF, 1'b1, 33'h1_FFFF_FFFF}, 1'b1,
          '{1'b1, 13'h0000, 1'b0, 1'b0, 27'd0}},
        '{ROW_CFG,  CFG_RELOCK,     3'd1, '0, 1'b0, '0},
        // change of lock: table and reference restart on this PCR
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1FFF, 1'b1, 33'd7}, 1'b1,
          '{1'b1, 13'h1FFF, 1'b1, 1'b1, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1FFF, 1'b1, 33'd97}, 1'b0, '0},
        // zero threshold locks at the first occurrence
        '{ROW_CFG,  CFG_RELOCK,     3'd0, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0AAA, 1'b1, 33'h0_AAAA_AAAA}, 1'b1,
          '{1'b1, 13'h0AAA, 1'b1, 1'b1, 27'd0}},
        '{ROW_CFG,  CFG_RELOCK,     3'd7, '0, 1'b0, '0},
        '{ROW_CFG,  CFG_FIRST_LOCK, 3'd7, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1555, 1'b1, 33'h1_5555_5555}, 1'b1,
          '{1'b1, 13'h0AAA, 1'b0, 1'b0, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1555, 1'b1, 33'h0}, 1'b0, '0},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0AAA, 1'b1, 33'h0_AAAA_AD20}, 1'b0, '0},
        // locked PID cleared the table, so the count starts over
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h1555, 1'b1, 33'd1}, 1'b1,
          '{1'b1, 13'h0AAA, 1'b0, 1'b0, 27'd0}},
        '{ROW_ITEM, CFG_FIRST_LOCK, 3'd0, '{1'b0, 13'h0AAA, 1'b1, 33'h0}, 1'b0, '0}
    };

    // share: locked PID, pool: few recurring PIDs, flood: fresh PIDs, rest: no PCR
    t_phase plan [10] = '{
        '{3'd1, 3'd2, 30, 40, 10},
        '{3'd7, 3'd7,  1,  5, 80},
        '{3'd0, 3'd1, 20, 40, 15},
        '{3'd3, 3'd0, 25, 35, 15},
        '{3'd2, 3'd4, 10, 60, 10},
        '{3'd5, 3'd6,  2, 10, 70},
        '{3'd4, 3'd3, 40, 30, 10},
        '{3'd6, 3'd5, 15, 50, 15},
        '{3'd1, 3'd7, 20, 55,  5},
        '{3'd7, 3'd1, 35, 30, 20}
    };

    pcr_pid_lock_and_pacing_top #(
        .TABLE_DEPTH (CAND_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 clk = ~clk;

    initial begin
        foreach (cand_hits[i]) begin
            cand_hits[i] = '0;
            cand_pids[i] = '0;
        end
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 38);
    endfunction

    // Advance the lock table and reference for one packet and form its result.
    function automatic t_out_item lock_and_pace(t_in_item it);
        t_out_item        r;
        logic             hit;
        logic             found;
        logic [CNT_W-1:0] thr;
        logic [CNT_W-1:0] cnt;
        logic [PCR_W-1:0] ticks;
        r = '0;
        if (it.resync)
            base_known = 1'b0;
        if (it.pcr_present) begin
            hit = clk_pid_locked && (it.pid == clk_pid);
            if (!hit) begin
                thr = clk_pid_locked ? relock_thr : first_thr;
                if (thr == '0)
                    thr = CNT_W'(1);
                cnt = '0;
                found = 1'b0;
                for (int i = 0; i < CAND_DEPTH; i++) begin
                    if (!found && cand_hits[i] != '0 && cand_pids[i] == it.pid) begin
                        found = 1'b1;
                        if (cand_hits[i] != CNT_MAX)
                            cand_hits[i] = cand_hits[i] + 1'b1;
                        cnt = cand_hits[i];
                    end
                end
                // take the first empty entry; drop the PID when none is left
                for (int i = 0; i < CAND_DEPTH; i++) begin
                    if (!found && cand_hits[i] == '0) begin
                        found = 1'b1;
                        cand_pids[i] = it.pid;
                        cand_hits[i] = CNT_W'(1);
                        cnt = CNT_W'(1);
                    end
                end
                if (cnt != '0 && cnt >= thr) begin
                    clk_pid_locked = 1'b1;
                    clk_pid = it.pid;
                    base_known = 1'b0;
                    hit = 1'b1;
                end
            end
            if (hit) begin
                foreach (cand_hits[i]) begin
                    cand_hits[i] = '0;
                    cand_pids[i] = '0;
                end
                r.pcr_update = 1'b1;
                if (!base_known) begin
                    base_pcr = it.pcr_value;
                    base_known = 1'b1;
                    r.timing_restarted = 1'b1;
                end
                ticks = it.pcr_value - base_pcr;
                r.elapsed_ms = MS_W'(ticks / TICKS_PER_MS);
            end
        end
        r.lock_valid = clk_pid_locked;
        r.locked_pid = clk_pid_locked ? clk_pid : '0;
        return r;
    endfunction

    function automatic t_in_item make_packet(t_phase p);
        t_in_item    it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        stream_pcr = stream_pcr + PCR_W'($urandom_range(0, 3600));
        it.resync = ($urandom_range(0, 39) == 0);
        it.pcr_present = 1'b1;
        it.pcr_value = stream_pcr;
        if ($urandom_range(0, 19) == 0)
            it.pcr_value = {1'($urandom_range(0, 1)), $urandom()};
        if (roll < p.share) begin
            it.pid = clk_pid_locked ? clk_pid : pid_pool[0];
        end else if (roll < p.share + p.pool) begin
            it.pid = pid_pool[$urandom_range(0, POOL_N - 1)];
        end else if (roll < p.share + p.pool + p.flood) begin
            it.pid = PID_W'($urandom_range(0, 8191));
        end else begin
            it.pid = PID_W'($urandom_range(0, 8191));
            it.pcr_present = 1'b0;
        end
        return it;
    endfunction

    task automatic report_fault(input string what, input longint unsigned got,
                                input longint unsigned want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        faults++;
    endtask

    // Write a register once every result is out and the input is quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        cfg_we <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CFG_FIRST_LOCK)
            first_thr = val;
        else
            relock_thr = val;
        @(posedge clk);
    endtask

    task automatic push_item(input t_in_item it, input logic chk, input t_out_item want);
        cfg_we <= 1'b0;
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        row_check <= chk;
        row_want <= want;
        do @(posedge clk); while (o_in_stall);
    endtask

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && items_in >= HOLD_AT) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= take_break();
        end
    end

    // predict on input acceptance, check on output acceptance, watch for a hang
    initial begin
        t_out_item   want;
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                quiet++;
                if (in_valid && !o_in_stall) begin
                    want = lock_and_pace(in_item);
                    if (row_check)
                        want = row_want;
                    pending_results = {pending_results, want};
                    items_in <= items_in + 1;
                    quiet = 0;
                end
                if (o_out_valid && !out_stall) begin
                    quiet = 0;
                    if (pending_results.size() == 0) begin
                        report_fault("unexpected result", 64'(o_out_item), 64'd0);
                    end else begin
                        want = pending_results.pop_front();
                        if (o_out_item.lock_valid !== want.lock_valid)
                            report_fault("lock_valid", 64'(o_out_item.lock_valid),
                                         64'(want.lock_valid));
                        if (o_out_item.locked_pid !== want.locked_pid)
                            report_fault("locked_pid", 64'(o_out_item.locked_pid),
                                         64'(want.locked_pid));
                        if (o_out_item.pcr_update !== want.pcr_update)
                            report_fault("pcr_update", 64'(o_out_item.pcr_update),
                                         64'(want.pcr_update));
                        if (o_out_item.timing_restarted !== want.timing_restarted)
                            report_fault("timing_restarted", 64'(o_out_item.timing_restarted),
                                         64'(want.timing_restarted));
                        if (o_out_item.elapsed_ms !== want.elapsed_ms)
                            report_fault("elapsed_ms", 64'(o_out_item.elapsed_ms),
                                         64'(want.elapsed_ms));
                    end
                end
                if (quiet >= QUIET_LIMIT) begin
                    $display("[pcr_pid_lock_and_pacing_top] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_CFG)
                write_reg(script[r].cfg_sel, script[r].cfg_val);
            else
                push_item(script[r].pkt, script[r].check, script[r].want);
        end

        foreach (plan[ph]) begin
            write_reg(CFG_FIRST_LOCK, plan[ph].first);
            write_reg(CFG_RELOCK, plan[ph].relock);
            steady <= (ph == 6);
            foreach (pid_pool[k])
                pid_pool[k] = PID_W'($urandom_range(0, 8191));
            stream_pcr = {1'($urandom_range(0, 1)), $urandom()};
            repeat (ITEMS_PER_PHASE)
                push_item(make_packet(plan[ph]), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (faults == 0)
            $display("[pcr_pid_lock_and_pacing_top] OK");
        else
            $display("[pcr_pid_lock_and_pacing_top] ERROR");
        $finish;
    end

endmodule
